FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mck_pkg.sv
// ---------------------------------------------------------------------------
// mck_pkg
// Types, code table and control store for the Morse code keyer.
// ---------------------------------------------------------------------------
package mck_pkg;

    localparam int CHAR_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int DUR_W   = 19;
    localparam int TDATA_W = 24;
    localparam int PAT_W   = 7;
    localparam int LEN_W   = 3;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd100;

    // end-of-work prosign ...-.- , bit 0 is the first symbol, 1 = dash
    localparam logic [PAT_W-1:0] PROSIGN_PAT = 7'b0101000;
    localparam logic [LEN_W-1:0] PROSIGN_LEN = 3'd6;

    typedef enum logic [1:0] {
        UNITS_0 = 2'd0,
        UNITS_1 = 2'd1,
        UNITS_3 = 2'd2,
        UNITS_7 = 2'd3
    } units_t;

    typedef enum logic [2:0] {
        STEP_FETCH = 3'd0,
        STEP_MARK  = 3'd1,
        STEP_SPACE = 3'd2,
        STEP_GAP   = 3'd3,
        STEP_WORD  = 3'd4,
        STEP_UNK   = 3'd5
    } step_t;

    typedef enum logic [1:0] {
        COND_NEXT     = 2'd0,
        COND_DISPATCH = 2'd1,
        COND_MORE     = 2'd2
    } cond_t;

    typedef enum logic [1:0] {
        LAST_NO      = 2'd0,
        LAST_YES     = 2'd1,
        LAST_PROSIGN = 2'd2
    } last_mode_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       key;
        logic       mark_len;
        units_t     units;
        logic       unknown;
        last_mode_t last_mode;
        logic       shift;
        cond_t      cond;
        step_t      target_a;
        step_t      target_b;
    } ctrl_t;

    typedef struct packed {
        logic   emit;
        logic   key_down;
        units_t units;
        logic   unknown;
        logic   last;
    } seg_t;

    typedef struct packed {
        logic             known;
        logic             space;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
    } code_t;

    function automatic ctrl_t microcode(input step_t step);
        ctrl_t c;
        c = '{load: 1'b0, emit: 1'b0, key: 1'b0, mark_len: 1'b0, units: UNITS_0,
              unknown: 1'b0, last_mode: LAST_NO, shift: 1'b0, cond: COND_NEXT,
              target_a: STEP_FETCH, target_b: STEP_FETCH};
        case (step)
            STEP_FETCH:
            begin
                c.load = 1'b1;
                c.cond = COND_DISPATCH;
            end
            STEP_MARK:
            begin
                c.emit     = 1'b1;
                c.key      = 1'b1;
                c.mark_len = 1'b1;
                c.target_a = STEP_SPACE;
            end
            STEP_SPACE:
            begin
                c.emit      = 1'b1;
                c.units     = UNITS_1;
                c.last_mode = LAST_PROSIGN;
                c.shift     = 1'b1;
                c.cond      = COND_MORE;
                c.target_a  = STEP_MARK;
                c.target_b  = STEP_GAP;
            end
            STEP_GAP:
            begin
                c.emit      = 1'b1;
                c.units     = UNITS_3;
                c.last_mode = LAST_YES;
            end
            STEP_WORD:
            begin
                c.emit     = 1'b1;
                c.units    = UNITS_7;
                c.target_a = STEP_GAP;
            end
            STEP_UNK:
            begin
                c.emit      = 1'b1;
                c.unknown   = 1'b1;
                c.last_mode = LAST_YES;
            end
            default:
            begin
                c.target_a = STEP_FETCH;
            end
        endcase
        return c;
    endfunction

    // pattern: bit 0 is the first symbol, 1 = dash
    function automatic code_t code_lookup(input logic [CHAR_W-1:0] ch);
        code_t r;
        r = '{known: 1'b1, space: 1'b0, len: 3'd0, pat: 7'b0};
        case (ch)
            8'h61: begin r.len = 3'd2; r.pat = 7'b0000010; end // a
            8'h62: begin r.len = 3'd4; r.pat = 7'b0000001; end // b
            8'h63: begin r.len = 3'd4; r.pat = 7'b0000101; end // c
            8'h64: begin r.len = 3'd3; r.pat = 7'b0000001; end // d
            8'h65: begin r.len = 3'd1; r.pat = 7'b0000000; end // e
            8'h66: begin r.len = 3'd4; r.pat = 7'b0000100; end // f
            8'h67: begin r.len = 3'd3; r.pat = 7'b0000011; end // g
            8'h68: begin r.len = 3'd4; r.pat = 7'b0000000; end // h
            8'h69: begin r.len = 3'd2; r.pat = 7'b0000000; end // i
            8'h6A: begin r.len = 3'd4; r.pat = 7'b0001110; end // j
            8'h6B: begin r.len = 3'd3; r.pat = 7'b0000101; end // k
            8'h6C: begin r.len = 3'd4; r.pat = 7'b0000010; end // l
            8'h6D: begin r.len = 3'd2; r.pat = 7'b0000011; end // m
            8'h6E: begin r.len = 3'd2; r.pat = 7'b0000001; end // n
            8'h6F: begin r.len = 3'd3; r.pat = 7'b0000111; end // o
            8'h70: begin r.len = 3'd4; r.pat = 7'b0000110; end // p
            8'h71: begin r.len = 3'd4; r.pat = 7'b0001011; end // q
            8'h72: begin r.len = 3'd3; r.pat = 7'b0000010; end // r
            8'h73: begin r.len = 3'd3; r.pat = 7'b0000000; end // s
            8'h74: begin r.len = 3'd1; r.pat = 7'b0000001; end // t
            8'h75: begin r.len = 3'd3; r.pat = 7'b0000100; end // u
            8'h76: begin r.len = 3'd4; r.pat = 7'b0001000; end // v
            8'h77: begin r.len = 3'd3; r.pat = 7'b0000110; end // w
            8'h78: begin r.len = 3'd4; r.pat = 7'b0001001; end // x
            8'h79: begin r.len = 3'd4; r.pat = 7'b0001101; end // y
            8'h7A: begin r.len = 3'd4; r.pat = 7'b0000011; end // z
            8'h30: begin r.len = 3'd5; r.pat = 7'b0011111; end // 0
            8'h31: begin r.len = 3'd5; r.pat = 7'b0011110; end // 1
            8'h32: begin r.len = 3'd5; r.pat = 7'b0011100; end // 2
            8'h33: begin r.len = 3'd5; r.pat = 7'b0011000; end // 3
            8'h34: begin r.len = 3'd5; r.pat = 7'b0010000; end // 4
            8'h35: begin r.len = 3'd5; r.pat = 7'b0000000; end // 5
            8'h36: begin r.len = 3'd5; r.pat = 7'b0000001; end // 6
            8'h37: begin r.len = 3'd5; r.pat = 7'b0000011; end // 7
            8'h38: begin r.len = 3'd5; r.pat = 7'b0000111; end // 8
            8'h39: begin r.len = 3'd5; r.pat = 7'b0001111; end // 9
            8'h2E: begin r.len = 3'd6; r.pat = 7'b0101010; end // period
            8'h2C: begin r.len = 3'd6; r.pat = 7'b0110011; end // comma
            8'h3F: begin r.len = 3'd6; r.pat = 7'b0001100; end // question mark
            8'h27: begin r.len = 3'd6; r.pat = 7'b0011110; end // apostrophe
            8'h21: begin r.len = 3'd6; r.pat = 7'b0110101; end // exclamation
            8'h2F: begin r.len = 3'd5; r.pat = 7'b0001001; end // slash
            8'h28: begin r.len = 3'd5; r.pat = 7'b0001101; end // open paren
            8'h29: begin r.len = 3'd6; r.pat = 7'b0101101; end // close paren
            8'h3A: begin r.len = 3'd6; r.pat = 7'b0000111; end // colon
            8'h3B: begin r.len = 3'd6; r.pat = 7'b0010101; end // semicolon
            8'h3D: begin r.len = 3'd5; r.pat = 7'b0010001; end // equals
            8'h2B: begin r.len = 3'd5; r.pat = 7'b0001010; end // plus
            8'h2D: begin r.len = 3'd6; r.pat = 7'b0100001; end // hyphen
            8'h5F: begin r.len = 3'd6; r.pat = 7'b0101100; end // underscore
            8'h22: begin r.len = 3'd6; r.pat = 7'b0010010; end // quote
            8'h24: begin r.len = 3'd7; r.pat = 7'b1001000; end // dollar
            8'h40: begin r.len = 3'd6; r.pat = 7'b0010110; end // at sign
            8'h20: begin r.space = 1'b1; end                    // word space
            default: begin r.known = 1'b0; end
        endcase
        return r;
    endfunction

endpackage

FILE: sv/morse_code_keyer_top.sv
// ---------------------------------------------------------------------------
// morse_code_keyer_top
// Morse code keyer: one character in, a run of timed keying segments out.
//
//   channel   dir  tdata                     tuser                      tlast
//   s_*       in   [7:0] character           [0] end_of_message         -
//   m_*       out  [18:0] duration_ticks     [0] key_down [1] unknown   last
//   unit_*    in   [15:0] unit_ticks (write enable, no read-back)
//
// A character is taken in the fetch step, then one segment per cycle, one for each
// step the control store runs, while m_tready does not stall.
// Reset clears the sequencer and output valid; unit_ticks returns to 100.
// m_tready low freezes the step counter on the pending segment.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module morse_code_keyer_top
    import mck_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] character
    input  logic               s_tuser,   // [0] end_of_message
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [18:0] duration_ticks, rest zero
    output logic [1:0]         m_tuser,   // [0] key_down, [1] unknown_char
    output logic               m_tlast,
    input  logic               unit_ticks_we,
    input  logic [UNIT_W-1:0]  unit_ticks_wdata
);

    logic [UNIT_W-1:0] unit_ticks_reg;
    logic              valid_reg, valid_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic              key_reg, key_next;
    logic              unk_reg, unk_next;
    logic              last_reg, last_next;

    seg_t             seg;
    logic             hold;
    logic [DUR_W-1:0] ext;

    mck_sequencer u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .character      (s_tdata),
        .end_of_message (s_tuser),
        .hold           (hold),
        .seg            (seg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (unit_ticks_we)
            begin
                unit_ticks_reg <= unit_ticks_wdata;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg  <= dur_next;
        key_reg  <= key_next;
        unk_reg  <= unk_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        hold = valid_reg && !m_tready;
        ext  = {{(DUR_W-UNIT_W){1'b0}}, unit_ticks_reg};

        valid_next = valid_reg && !m_tready;
        dur_next   = dur_reg;
        key_next   = key_reg;
        unk_next   = unk_reg;
        last_next  = last_reg;

        if (seg.emit && !hold)
        begin
            valid_next = 1'b1;
            key_next   = seg.key_down;
            unk_next   = seg.unknown;
            last_next  = seg.last;
            case (seg.units)
                UNITS_1: dur_next = ext;
                UNITS_3: dur_next = (ext << 1) + ext;
                UNITS_7: dur_next = (ext << 3) - ext;
                default: dur_next = '0;
            endcase
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_W-DUR_W){1'b0}}, dur_reg};
    assign m_tuser  = {unk_reg, key_reg};
    assign m_tlast  = last_reg;

    `ASSERT_IMP(a_unknown_is_zero_last, m_tvalid && m_tuser[1],
                m_tlast && (m_tdata == '0) && !m_tuser[0], "bad unknown segment")
    `ASSERT_IMP(a_key_down_not_last, m_tvalid && m_tuser[0], !m_tlast,
                "key-down segment marked last")
    `ASSERT_NXT(a_out_stable_stalled, m_tvalid && !m_tready,
                m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
                "segment changed while stalled")

endmodule

FILE: sv/mck_sequencer.sv
// ---------------------------------------------------------------------------
// mck_sequencer
// Microcoded step sequencer: walks one character's code, one segment a step after fetch.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mck_sequencer
    import mck_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] character,
    input  logic              end_of_message,
    input  logic              hold,
    output seg_t              seg
);

    step_t            step_reg, step_next;
    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             prosign_reg, prosign_next;

    ctrl_t ctrl;
    code_t lookup;
    logic  more;
    logic  adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_FETCH;
            cnt_reg     <= '0;
            prosign_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            prosign_reg <= prosign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_comb
    begin
        ctrl   = microcode(step_reg);
        lookup = code_lookup(character);
        more   = (cnt_reg > 3'd1);
        adv    = ctrl.load ? in_valid : !(ctrl.emit && hold);

        in_ready = ctrl.load;

        seg.emit     = ctrl.emit;
        seg.key_down = ctrl.key;
        seg.unknown  = ctrl.unknown;
        if (ctrl.mark_len)
        begin
            seg.units = pat_reg[0] ? UNITS_3 : UNITS_1;
        end
        else
        begin
            seg.units = ctrl.units;
        end
        case (ctrl.last_mode)
            LAST_YES:     seg.last = 1'b1;
            LAST_PROSIGN: seg.last = prosign_reg && !more;
            default:      seg.last = 1'b0;
        endcase

        step_next    = step_reg;
        pat_next     = pat_reg;
        cnt_next     = cnt_reg;
        prosign_next = prosign_reg;

        if (adv)
        begin
            case (ctrl.cond)
                COND_DISPATCH:
                begin
                    if (end_of_message)
                    begin
                        step_next = STEP_MARK;
                    end
                    else if (!lookup.known)
                    begin
                        step_next = STEP_UNK;
                    end
                    else if (lookup.space)
                    begin
                        step_next = STEP_WORD;
                    end
                    else
                    begin
                        step_next = STEP_MARK;
                    end
                end
                COND_MORE:
                begin
                    if (more)
                    begin
                        step_next = ctrl.target_a;
                    end
                    else if (prosign_reg)
                    begin
                        step_next = STEP_FETCH;
                    end
                    else
                    begin
                        step_next = ctrl.target_b;
                    end
                end
                default:
                begin
                    step_next = ctrl.target_a;
                end
            endcase

            if (ctrl.load)
            begin
                prosign_next = end_of_message;
                pat_next     = end_of_message ? PROSIGN_PAT : lookup.pat;
                cnt_next     = end_of_message ? PROSIGN_LEN : lookup.len;
            end
            if (ctrl.shift)
            begin
                pat_next = pat_reg >> 1;
                cnt_next = cnt_reg - 3'd1;
            end
        end
    end

    `ASSERT_IMP(a_mark_has_symbols, step_reg == STEP_MARK, cnt_reg != '0,
                "mark step with no symbols left")
    `ASSERT_NXT(a_stall_holds_step, ctrl.emit && hold,
                $stable(step_reg) && $stable(cnt_reg), "sequencer moved while stalled")
    `ASSERT_NXT(a_last_ends_item, seg.emit && seg.last && !hold,
                step_reg == STEP_FETCH, "last segment did not return to fetch")

endmodule

FILE: tb/morse_keying_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// morse_keying_checker
// Watches the character and segment channels of the Morse code keyer. Each
// accepted character is expanded into its keying segments at the current
// unit length. Each segment transfer is compared with the oldest expected
// segment. Unit length writes are tracked from the configuration port.
// ---------------------------------------------------------------------------
module morse_keying_checker
    import mck_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser,
    input  logic               m_tlast,
    input  logic               unit_ticks_we,
    input  logic [UNIT_W-1:0]  unit_ticks_wdata,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic             key_down;
        logic [DUR_W-1:0] duration;
        logic             unknown;
        logic             last;
    } segment_t;

    localparam string END_OF_WORK = "...-.-";

    segment_t          segments_due[$];
    logic [UNIT_W-1:0] unit_len;

    // "w" marks a word space
    function automatic string code_of(input logic [CHAR_W-1:0] c);
        case (c)
            "a": return ".-";      "b": return "-...";    "c": return "-.-.";
            "d": return "-..";     "e": return ".";       "f": return "..-.";
            "g": return "--.";     "h": return "....";    "i": return "..";
            "j": return ".---";    "k": return "-.-";     "l": return ".-..";
            "m": return "--";      "n": return "-.";      "o": return "---";
            "p": return ".--.";    "q": return "--.-";    "r": return ".-.";
            "s": return "...";     "t": return "-";       "u": return "..-";
            "v": return "...-";    "w": return ".--";     "x": return "-..-";
            "y": return "-.--";    "z": return "--..";    "0": return "-----";
            "1": return ".----";   "2": return "..---";   "3": return "...--";
            "4": return "....-";   "5": return ".....";   "6": return "-....";
            "7": return "--...";   "8": return "---..";   "9": return "----.";
            ".": return ".-.-.-";  ",": return "--..--";  "?": return "..--..";
            "'": return ".----.";  "!": return "-.-.--";  "/": return "-..-.";
            "(": return "-.--.";   ")": return "-.--.-";  ":": return "---...";
            ";": return "-.-.-.";  "=": return "-...-";   "+": return ".-.-.";
            "-": return "-....-";  "_": return "..--.-";  "\"": return ".-..-.";
            "$": return "...-..-"; "@": return ".--.-.";  " ": return "w";
            default: return "";
        endcase
    endfunction

    function automatic segment_t make_seg(input logic key, input int units,
                                          input logic unk);
        segment_t s;
        s.key_down = key;
        s.duration = DUR_W'(units * unit_len);
        s.unknown  = unk;
        s.last     = 1'b0;
        return s;
    endfunction

    function automatic void expand_char(input logic [CHAR_W-1:0] ch, input logic eom);
        segment_t run[16];
        int       n;
        string    code;
        n = 0;
        code = eom ? END_OF_WORK : code_of(ch);
        if (code.len() == 0)
        begin
            run[0] = make_seg(1'b0, 0, 1'b1);
            n = 1;
        end
        else
        begin
            for (int i = 0; i < code.len(); i++)
            begin
                if (code[i] == "w")
                begin
                    run[n] = make_seg(1'b0, 7, 1'b0);
                    n = n + 1;
                end
                else
                begin
                    run[n] = make_seg(1'b1, (code[i] == "-") ? 3 : 1, 1'b0);
                    run[n + 1] = make_seg(1'b0, 1, 1'b0);
                    n = n + 2;
                end
            end
            // prosign has no trailing character gap
            if (!eom)
            begin
                run[n] = make_seg(1'b0, 3, 1'b0);
                n = n + 1;
            end
        end
        run[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            segments_due.push_back(run[i]);
    endfunction

    always @(posedge clk)
    begin
        segment_t got;
        segment_t want;
        if (!rst_n)
        begin
            segments_due.delete();
            unit_len   = 16'd100;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (unit_ticks_we)
                unit_len = unit_ticks_wdata;
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tdata[DUR_W-1:0], m_tuser[1], m_tlast};
                if (segments_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected segment key %0d dur %0d unknown %0d last %0d",
                                 $realtime, got.key_down, got.duration, got.unknown,
                                 got.last);
                    fail_count++;
                end
                else
                begin
                    want = segments_due.pop_front();
                    if (got !== want || m_tdata[TDATA_W-1:DUR_W] !== '0)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch exp key %0d dur %0d unk %0d last %0d",
                                     $realtime, want.key_down, want.duration, want.unknown,
                                     want.last);
                            $display("    got key %0d dur %0d unk %0d last %0d tdata %h",
                                     got.key_down, got.duration, got.unknown, got.last,
                                     m_tdata);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expand_char(s_tdata, s_tuser);
            pending = segments_due.size();
        end
    end

endmodule

FILE: tb/morse_code_keyer_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// morse_code_keyer_top_tb
// Drives characters and end-of-message markers into the Morse code keyer
// over several unit lengths, extremes included, with random gaps and stalls
// on both channels and one long segment-side stall. Checking is done by
// morse_keying_checker.
// ---------------------------------------------------------------------------
module morse_code_keyer_top_tb
    import mck_pkg::*;
;

    localparam int    HOLD_CYCLES  = 300;
    localparam int    PHASE_ITEMS  = 24;
    localparam int    PHASES       = 8;
    localparam string KNOWN_CHARS  = "abcdefghijklmnopqrstuvwxyz0123456789.,?'!/():;=+-_\"$@ ";
    localparam string DIRECTED     = "eatg $0.?)_@";

    logic               clk;
    logic               rst_n            = 1'b0;
    logic               s_tvalid         = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata          = '0;
    logic               s_tuser          = 1'b0;
    logic               m_tvalid;
    logic               m_tready         = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;
    logic               unit_ticks_we    = 1'b0;
    logic [UNIT_W-1:0]  unit_ticks_wdata = '0;

    int fail_count;
    int pending;
    bit hold_off;
    bit steady_feed;

    morse_code_keyer_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .unit_ticks_we    (unit_ticks_we),
        .unit_ticks_wdata (unit_ticks_wdata)
    );

    morse_keying_checker keying_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .unit_ticks_we    (unit_ticks_we),
        .unit_ticks_wdata (unit_ticks_wdata),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_feed || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eom);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= eom;
        do
            @(posedge clk);
        while (!s_tready);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
        else if (r < 25)
            send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
        else
            send_char(KNOWN_CHARS[$urandom_range(0, KNOWN_CHARS.len() - 1)], 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_unit(input logic [UNIT_W-1:0] value);
        unit_ticks_we    <= 1'b1;
        unit_ticks_wdata <= value;
        @(posedge clk);
        unit_ticks_we    <= 1'b0;
    endtask

    // segment side: random ready pattern, one long hold-off on request
    initial
    begin
        int r;
        int on_len;
        int off_len;
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                on_len  = (r < 15) ? $urandom_range(40, 120) : $urandom_range(1, 8);
                r = $urandom_range(0, 99);
                off_len = (r < 90) ? $urandom_range(1, 3) : $urandom_range(15, 50);
                m_tready <= 1'b1;
                repeat (on_len) @(posedge clk);
                m_tready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [UNIT_W-1:0] unit;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset unit length: unknown codes, end markers, table corners
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("A", 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char("e", 1'b1);
        for (int i = 0; i < DIRECTED.len(); i++)
            send_char(DIRECTED[i], 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       unit = 16'hFFFF;
                1:       unit = 16'd1;
                2:       unit = 16'd0;
                default: unit = UNIT_W'($urandom_range(1, 65535));
            endcase
            write_unit(unit);
            steady_feed = (p == 3 || p == 5);
            if (p == 3)
                hold_off = 1'b1;
            if (p < 3)
            begin
                send_char("$", 1'b0);
                send_char(" ", 1'b0);
                send_char("0", 1'b1);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mck_pkg.sv
sv/mck_sequencer.sv
sv/morse_code_keyer_top.sv
tb/morse_keying_checker.sv
tb/morse_code_keyer_top_tb.sv
